[sv/fpst_pkg.sv]
// ----------------------------------------------------------------------------
// fpst_pkg
// Shared widths, request codes, status codes and register map of the
// Fenwick prefix-sum table.
// ----------------------------------------------------------------------------
package fpst_pkg;

    // Field widths
    localparam int OP_W      = 2;
    localparam int IDX_W     = 11;
    localparam int DATA_W    = 32;
    localparam int SIZE_W    = 11;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // Table depth default
    localparam int DEPTH_DEF = 1024;

    // Size register value after reset
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    // Request codes
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_SET   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
    localparam logic [OP_W-1:0] OP_RANGE = 2'd3;

    // Status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_BAD = 1'b1;

    // Register index (word address bit of paddr)
    localparam logic REG_SIZE = 1'b0;

endpackage

[sv/fenwick_prefix_sum_table_top.sv]
// ----------------------------------------------------------------------------
// fenwick_prefix_sum_table_top
// Binary indexed tree of 32-bit partial sums with a point-value store beside.
// ----------------------------------------------------------------------------
// Usage:
//   A request word on s_* (op, index, upper_index, operand_value) is taken
//   when s_valid and s_ready are high. It adds a delta, sets a value, reads a
//   point, or sums an inclusive range. One result word per request leaves on
//   m_* (result_value, status) under m_valid / m_ready.
//   The block holds one request at a time; s_ready is low until the result
//   word has been taken. Path from accept to m_valid: a point read passes
//   through the point-calculation state; add / set pass through it and then
//   walk the tree nodes on the update path (at most log2(size)+1); a range sum
//   walks the nodes on both prefix paths; a bad index goes straight to output.
//   The walk speed is set by the single read port of the partial-sum memory
//   and the one shared 32-bit adder: one tree node per cycle.
//   A stalled receiver simply holds the result word in m_*; nothing is lost.
//   After reset both memories are zeroed by a clearing pass over all DEPTH
//   entries, during which s_ready stays low; the size register (APB,
//   address 0) takes writes at any time and resets to 1024.
// ----------------------------------------------------------------------------
module fenwick_prefix_sum_table_top #(
    parameter int DEPTH = fpst_pkg::DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // request channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [fpst_pkg::OP_W-1:0]          s_op,
    input  logic [fpst_pkg::IDX_W-1:0]         s_index,
    input  logic [fpst_pkg::IDX_W-1:0]         s_upper_index,
    input  logic signed [fpst_pkg::DATA_W-1:0] s_operand_value,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [fpst_pkg::DATA_W-1:0] m_result_value,
    output logic                               m_status,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fpst_pkg::PADDR_W-1:0]       paddr,
    input  logic [fpst_pkg::PDATA_W-1:0]       pwdata,
    output logic [fpst_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    localparam int DW     = fpst_pkg::DATA_W;
    localparam int IW     = fpst_pkg::IDX_W;
    localparam int SW     = fpst_pkg::SIZE_W;
    localparam int AW     = $clog2(DEPTH);
    localparam int PW_MIN = $clog2(DEPTH) + 2;
    localparam int PW     = (PW_MIN > IW + 1) ? PW_MIN : IW + 1;

    localparam logic [AW-1:0] CLR_LAST  = AW'(DEPTH - 1);
    localparam logic [PW-1:0] DEPTH_POS = PW'(DEPTH);

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PCALC = 3'd2;
    localparam logic [2:0] S_UWALK = 3'd3;
    localparam logic [2:0] S_QWALK = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]    state_reg,  state_next;
    logic [AW-1:0] clr_reg,    clr_next;
    logic [SW-1:0] size_reg;
    logic          pend_reg,   pend_next;
    logic          pend_sub_reg, pend_sub_next;
    logic          phase_reg,  phase_next;

    logic [fpst_pkg::OP_W-1:0] op_reg, op_next;
    logic [PW-1:0] left_reg,   left_next;
    logic [DW-1:0] val_reg,    val_next;
    logic [DW-1:0] delta_reg,  delta_next;
    logic [PW-1:0] pos_reg,    pos_next;
    logic [AW-1:0] wpos_reg,   wpos_next;
    logic [DW-1:0] acc_reg,    acc_next;
    logic [DW-1:0] result_reg, result_next;
    logic          status_reg, status_next;

    logic [PW-1:0] eff_size;
    logic [PW-1:0] s_left;
    logic [PW-1:0] s_right;
    logic          left_ok;
    logic          right_ok;
    logic [PW-1:0] low_bit;
    logic [PW-1:0] pos_up;
    logic [PW-1:0] pos_dn;
    logic          pos_in;

    logic [DW-1:0] add_a;
    logic [DW-1:0] add_b;
    logic          add_sub;
    logic [DW-1:0] add_sum;
    logic [DW-1:0] new_point;

    logic          pt_we;
    logic [AW-1:0] pt_waddr;
    logic [DW-1:0] pt_wdata;
    logic [AW-1:0] pt_raddr;
    logic [DW-1:0] pt_rdata;
    logic          ts_we;
    logic [AW-1:0] ts_waddr;
    logic [DW-1:0] ts_wdata;
    logic [AW-1:0] ts_raddr;
    logic [DW-1:0] ts_rdata;

    logic          cfg_wr;

    // Point values and partial sums
    fpst_ram #(.AW(AW), .DW(DW)) u_point (
        .aclk  (aclk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    fpst_ram #(.AW(AW), .DW(DW)) u_tree (
        .aclk  (aclk),
        .we    (ts_we),
        .waddr (ts_waddr),
        .wdata (ts_wdata),
        .raddr (ts_raddr),
        .rdata (ts_rdata)
    );

    // Clamp the size register to the table depth
    always_comb begin
        if (PW'(size_reg) > DEPTH_POS) begin
            eff_size = DEPTH_POS;
        end else begin
            eff_size = PW'(size_reg);
        end
    end

    // Index checks on the incoming word
    assign s_left   = PW'(s_index);
    assign s_right  = PW'(s_upper_index);
    assign left_ok  = (s_left != '0) && (s_left <= eff_size);
    assign right_ok = (s_right != '0) && (s_right <= eff_size);

    // Tree walk steps
    assign low_bit = pos_reg & (~pos_reg + PW'(1));
    assign pos_up  = pos_reg + low_bit;
    assign pos_dn  = pos_reg & (pos_reg - PW'(1));
    assign pos_in  = (pos_reg != '0) && (pos_reg <= eff_size);

    // Shared adder / subtractor
    assign add_sum = add_a + (add_sub ? ~add_b : add_b) + DW'(add_sub);

    // Read addresses: point store follows the request, tree follows the walk
    assign pt_raddr = AW'(s_left - PW'(1));
    assign ts_raddr = AW'(pos_reg - PW'(1));

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        pend_next     = pend_reg;
        pend_sub_next = pend_sub_reg;
        phase_next    = phase_reg;
        op_next       = op_reg;
        left_next     = left_reg;
        val_next      = val_reg;
        delta_next    = delta_reg;
        pos_next      = pos_reg;
        wpos_next     = wpos_reg;
        acc_next      = acc_reg;
        result_next   = result_reg;
        status_next   = status_reg;
        add_a         = acc_reg;
        add_b         = ts_rdata;
        add_sub       = 1'b0;
        new_point     = val_reg;
        pt_we         = 1'b0;
        pt_waddr      = AW'(left_reg - PW'(1));
        pt_wdata      = new_point;
        ts_we         = 1'b0;
        ts_waddr      = wpos_reg;
        ts_wdata      = add_sum;

        unique case (state_reg)
            // Zero both stores, one entry per cycle
            S_CLEAR: begin
                pt_we    = 1'b1;
                pt_waddr = clr_reg;
                pt_wdata = '0;
                ts_we    = 1'b1;
                ts_waddr = clr_reg;
                ts_wdata = '0;
                if (clr_reg == CLR_LAST) begin
                    state_next = S_IDLE;
                end else begin
                    clr_next = clr_reg + AW'(1);
                end
            end

            // Take a request word and check its indices
            S_IDLE: begin
                if (s_valid) begin
                    op_next   = s_op;
                    left_next = s_left;
                    val_next  = s_operand_value;
                    if (!left_ok || (s_op == fpst_pkg::OP_RANGE && !right_ok)) begin
                        result_next = '0;
                        status_next = fpst_pkg::ST_BAD;
                        state_next  = S_OUT;
                    end else begin
                        status_next = fpst_pkg::ST_OK;
                        if (s_op == fpst_pkg::OP_RANGE) begin
                            pos_next   = s_right;
                            acc_next   = '0;
                            phase_next = 1'b0;
                            pend_next  = 1'b0;
                            state_next = S_QWALK;
                        end else begin
                            state_next = S_PCALC;
                        end
                    end
                end
            end

            // Point value is in; form the delta and the new point value (a read passes it on)
            S_PCALC: begin
                unique case (op_reg)
                    fpst_pkg::OP_ADD: begin
                        add_a      = pt_rdata;
                        add_b      = val_reg;
                        add_sub    = 1'b0;
                        new_point  = add_sum;
                        delta_next = val_reg;
                    end
                    fpst_pkg::OP_SET: begin
                        add_a      = val_reg;
                        add_b      = pt_rdata;
                        add_sub    = 1'b1;
                        new_point  = val_reg;
                        delta_next = add_sum;
                    end
                    default: begin
                        new_point = pt_rdata;
                    end
                endcase
                pt_wdata    = new_point;
                result_next = new_point;
                if (op_reg == fpst_pkg::OP_ADD || op_reg == fpst_pkg::OP_SET) begin
                    pt_we      = 1'b1;
                    pos_next   = left_reg;
                    pend_next  = 1'b0;
                    state_next = S_UWALK;
                end else begin
                    state_next = S_OUT;
                end
            end

            // Update walk: read node ahead, write back node read last cycle
            S_UWALK: begin
                add_a   = ts_rdata;
                add_b   = delta_reg;
                add_sub = 1'b0;
                ts_we   = pend_reg;
                if (pos_in) begin
                    pend_next = 1'b1;
                    wpos_next = ts_raddr;
                    pos_next  = pos_up;
                end else begin
                    pend_next  = 1'b0;
                    state_next = S_OUT;
                end
            end

            // Query walk: add prefix(right), then subtract prefix(left - 1)
            S_QWALK: begin
                add_a   = acc_reg;
                add_b   = ts_rdata;
                add_sub = pend_sub_reg;
                if (pend_reg) begin
                    acc_next = add_sum;
                end
                if (pos_reg != '0) begin
                    pend_next     = 1'b1;
                    pend_sub_next = phase_reg;
                    pos_next      = pos_dn;
                end else begin
                    pend_next = 1'b0;
                    if (!phase_reg) begin
                        phase_next = 1'b1;
                        pos_next   = left_reg - PW'(1);
                    end else begin
                        result_next = acc_next;
                        state_next  = S_OUT;
                    end
                end
            end

            // Hold the result word until taken
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            pend_reg     <= 1'b0;
            pend_sub_reg <= 1'b0;
            phase_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            pend_reg     <= pend_next;
            pend_sub_reg <= pend_sub_next;
            phase_reg    <= phase_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        left_reg   <= left_next;
        val_reg    <= val_next;
        delta_reg  <= delta_next;
        pos_reg    <= pos_next;
        wpos_reg   <= wpos_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
        status_reg <= status_next;
    end

    // Configuration register
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= fpst_pkg::SIZE_RESET;
        end else if (cfg_wr && paddr[2] == fpst_pkg::REG_SIZE) begin
            size_reg <= pwdata[SW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == fpst_pkg::REG_SIZE) ?
                    {{(fpst_pkg::PDATA_W - SW){1'b0}}, size_reg} : '0;

    // Channel outputs
    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = (state_reg == S_OUT);
    assign m_result_value = result_reg;
    assign m_status       = status_reg;

    // Never take a request while a result word is waiting
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("request taken while result pending");

    // A flagged result carries zero
    a_bad_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_result_value == '0))
        else $error("bad-index result not zero");

    // Index zero is flagged on the next cycle
    a_zero_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_index == '0) |=> (m_valid && m_status))
        else $error("index zero not flagged");

    // Clearing pass blocks requests right after reset
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_ready)
        else $error("request taken during clearing pass");

    // A point read at a valid index passes through the point-calculation state, then raises m_valid
    a_read_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_op == fpst_pkg::OP_READ && left_ok) |=> ##1 m_valid)
        else $error("point read latency wrong");

endmodule

[sv/fpst_ram.sv]
// ----------------------------------------------------------------------------
// fpst_ram
// Simple dual-port memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fpst_ram #(
    parameter int AW = 10,
    parameter int DW = fpst_pkg::DATA_W
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    localparam int WORDS = 1 << AW;

    logic [DW-1:0] mem [WORDS];
    logic [DW-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
